/* rtl/sobel_edge_threshold_top_assert.svh */
// Assertion macros shared by the Sobel edge detector RTL.
`ifndef SOBEL_EDGE_THRESHOLD_TOP_ASSERT_SVH
`define SOBEL_EDGE_THRESHOLD_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SOBEL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SOBEL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sobel_pkg.sv */
// Shared types and constants of the Sobel edge detector.
package sobel_pkg;

    typedef logic [7:0]         pix_t;
    typedef logic signed [10:0] grad_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_MODE      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 2'd3;

    localparam logic [7:0]  THRESHOLD_RESET = 8'd245;
    localparam logic        MODE_RESET      = 1'b0;
    localparam logic [11:0] WIDTH_RESET     = 12'd640;
    localparam logic [12:0] HEIGHT_RESET    = 13'd480;

endpackage

/* rtl/sobel_stream_if.sv */
// Pixel and result stream interfaces of the Sobel edge detector.
interface sobel_pixel_if import sobel_pkg::*; ();
    logic valid;
    logic ready;
    pix_t pixel_value;
    logic start_of_frame;

    modport source (output valid, output pixel_value, output start_of_frame, input ready);
    modport sink (input valid, input pixel_value, input start_of_frame, output ready);
endinterface

interface sobel_result_if import sobel_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        edge_flag;
    logic [11:0] center_row;
    logic [10:0] center_col;
    grad_t       grad_x;
    grad_t       grad_y;

    modport source (output valid, output edge_flag, output center_row, output center_col,
                    output grad_x, output grad_y, input ready);
    modport sink (input valid, input edge_flag, input center_row, input center_col,
                  input grad_x, input grad_y, output ready);
endinterface

/* rtl/sobel_line_store.sv */
// One row of pixels: single-port-write, registered-read line memory.
module sobel_line_store import sobel_pkg::*; #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output pix_t              rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pix_t              wr_data
);

    pix_t mem [DEPTH];
    pix_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns old data on a same-address write; caller forwards
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/sobel_edge_threshold_top.sv */
// Top level of the streaming 3x3 Sobel edge detector with threshold.
// Accepts one gray pixel per clock in raster order and returns one result word per pixel
// whose row and column are both at least 1, describing the pixel one row up and one column
// left. Each result passes in order through the line store read, window, gradients,
// squares and compare stages. Sustained rate is one pixel per cycle, set by the two line
// stores, each doing one read and one write per cycle; a stalled result output holds the
// whole pipeline. The line stores have no reset and need no clearing pass: entries not yet
// written only reach border centers, whose outputs are forced to zero.
`include "sobel_edge_threshold_top_assert.svh"

module sobel_edge_threshold_top import sobel_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    sobel_pixel_if.sink            pixels,
    sobel_result_if.source         results
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    typedef struct packed {
        logic        emit;
        logic        border;
        logic [11:0] row;
        logic [10:0] col;
    } meta_t;

    // configuration
    logic [7:0]  threshold_reg;
    logic        mode_reg;
    logic [11:0] width_reg;
    logic [12:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            mode_reg      <= MODE_RESET;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_EDGE_THRESHOLD: threshold_reg <= cfg_data[7:0];
                REG_EDGE_MODE:      mode_reg      <= cfg_data[0];
                REG_IMAGE_WIDTH:    width_reg     <= cfg_data[11:0];
                REG_IMAGE_HEIGHT:   height_reg    <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // effective frame size, saturated to 1..MAX
    logic [COL_W:0] w_eff;
    logic [ROW_W:0] h_eff;

    always_comb
    begin
        if (width_reg == 12'd0)
            w_eff = (COL_W+1)'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = (COL_W+1)'(MAX_WIDTH);
        else
            w_eff = (COL_W+1)'(width_reg);

        if (height_reg == 13'd0)
            h_eff = (ROW_W+1)'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = (ROW_W+1)'(MAX_HEIGHT);
        else
            h_eff = (ROW_W+1)'(height_reg);
    end

    // pipeline control: everything advances together when the output can move
    logic out_valid_reg;
    logic en;
    logic acc;

    assign en           = !out_valid_reg || results.ready;
    assign pixels.ready = en;
    assign acc          = pixels.valid && en;

    // position counters
    logic [COL_W-1:0] col_reg, col_next, cur_col;
    logic [ROW_W-1:0] row_reg, row_next, cur_row;
    logic [COL_W:0]   col_p1;
    logic [ROW_W:0]   row_p1;
    logic [31:0]      row_m1, col_m1;
    meta_t            in_meta;

    always_comb
    begin
        cur_col = pixels.start_of_frame ? '0 : col_reg;
        cur_row = pixels.start_of_frame ? '0 : row_reg;
        col_p1  = {1'b0, cur_col} + (COL_W+1)'(1);
        row_p1  = {1'b0, cur_row} + (ROW_W+1)'(1);

        if (col_p1 >= w_eff)
        begin
            col_next = '0;
            row_next = (row_p1 >= h_eff) ? '0 : row_p1[ROW_W-1:0];
        end
        else
        begin
            col_next = col_p1[COL_W-1:0];
            row_next = cur_row;
        end

        row_m1 = 32'(cur_row) - 32'd1;
        col_m1 = 32'(cur_col) - 32'd1;
        in_meta.emit   = (cur_row != '0) && (cur_col != '0);
        // center on first/last row or column
        in_meta.border = (cur_row == ROW_W'(1)) || (cur_col == COL_W'(1))
                         || ({1'b0, cur_col} >= w_eff) || ({1'b0, cur_row} >= h_eff);
        in_meta.row    = row_m1[11:0];
        in_meta.col    = col_m1[10:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage A: line store read in flight
    logic             a_valid_reg;
    meta_t            a_meta_reg;
    pix_t             a_pix_reg;
    logic [COL_W-1:0] a_slot_reg;
    logic             a_fwd_reg;
    pix_t             a_fwd_top_reg, a_fwd_mid_reg;
    pix_t             rd_a, rd_b;
    pix_t             a_top, a_mid;
    logic             a_write;
    logic             fwd_hit;

    assign a_top   = a_fwd_reg ? a_fwd_top_reg : rd_b;
    assign a_mid   = a_fwd_reg ? a_fwd_mid_reg : rd_a;
    assign a_write = en && a_valid_reg;
    // new read hits the slot being written back this cycle
    assign fwd_hit = a_valid_reg && (a_slot_reg == cur_col);

    sobel_line_store #(.DEPTH(MAX_WIDTH), .ADDR_W(COL_W)) line_store_a (
        .clk     (clk),
        .rd_en   (acc),
        .rd_addr (cur_col),
        .rd_data (rd_a),
        .wr_en   (a_write),
        .wr_addr (a_slot_reg),
        .wr_data (a_pix_reg)
    );

    sobel_line_store #(.DEPTH(MAX_WIDTH), .ADDR_W(COL_W)) line_store_b (
        .clk     (clk),
        .rd_en   (acc),
        .rd_addr (cur_col),
        .rd_data (rd_b),
        .wr_en   (a_write),
        .wr_addr (a_slot_reg),
        .wr_data (a_mid)
    );

    // stage B: window holds this item's neighborhood
    logic  b_valid_reg;
    meta_t b_meta_reg;
    pix_t  win_reg [9];

    // stage C: gradients
    logic  c_valid_reg;
    meta_t c_meta_reg;
    grad_t c_gx_reg, c_gy_reg;

    // stage D: squares and |gx| test
    logic        d_valid_reg;
    meta_t       d_meta_reg;
    grad_t       d_gx_reg, d_gy_reg;
    logic [19:0] d_gx2_reg, d_gy2_reg;
    logic [15:0] d_thr2_reg;
    logic        d_ax_ge_reg;

    // output register
    logic        out_flag_reg;
    logic [11:0] out_row_reg;
    logic [10:0] out_col_reg;
    grad_t       out_gx_reg, out_gy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            a_valid_reg   <= acc;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            out_valid_reg <= d_valid_reg && d_meta_reg.emit;
            if (a_valid_reg)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k*3]   <= win_reg[k*3+1];
                    win_reg[k*3+1] <= win_reg[k*3+2];
                end
                win_reg[2] <= a_top;
                win_reg[5] <= a_mid;
                win_reg[8] <= a_pix_reg;
            end
        end
    end

    // gradient arithmetic
    logic [9:0]         gx_pos, gx_neg, gy_pos, gy_neg;
    grad_t              gx, gy;
    logic signed [21:0] gx_sq, gy_sq;
    grad_t              c_ax;
    logic [20:0]        d_mag2;
    logic               d_flag;

    always_comb
    begin
        gx_pos = 10'(win_reg[2]) + {1'b0, win_reg[5], 1'b0} + 10'(win_reg[8]);
        gx_neg = 10'(win_reg[0]) + {1'b0, win_reg[3], 1'b0} + 10'(win_reg[6]);
        gy_pos = 10'(win_reg[0]) + {1'b0, win_reg[1], 1'b0} + 10'(win_reg[2]);
        gy_neg = 10'(win_reg[6]) + {1'b0, win_reg[7], 1'b0} + 10'(win_reg[8]);
        gx     = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
        gy     = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});

        gx_sq = 22'(c_gx_reg) * 22'(c_gx_reg);
        gy_sq = 22'(c_gy_reg) * 22'(c_gy_reg);
        c_ax  = c_gx_reg[10] ? -c_gx_reg : c_gx_reg;

        d_mag2 = {1'b0, d_gx2_reg} + {1'b0, d_gy2_reg};
        if (d_meta_reg.border)
            d_flag = 1'b0;
        else if (mode_reg)
            d_flag = d_ax_ge_reg;
        else
            d_flag = d_mag2 >= {5'd0, d_thr2_reg};
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            a_meta_reg    <= in_meta;
            a_pix_reg     <= pixels.pixel_value;
            a_slot_reg    <= cur_col;
            a_fwd_reg     <= fwd_hit;
            a_fwd_top_reg <= a_mid;
            a_fwd_mid_reg <= a_pix_reg;
        end
        if (en)
        begin
            b_meta_reg <= a_meta_reg;

            c_meta_reg <= b_meta_reg;
            c_gx_reg   <= b_meta_reg.border ? '0 : gx;
            c_gy_reg   <= b_meta_reg.border ? '0 : gy;

            d_meta_reg  <= c_meta_reg;
            d_gx_reg    <= c_gx_reg;
            d_gy_reg    <= c_gy_reg;
            d_gx2_reg   <= gx_sq[19:0];
            d_gy2_reg   <= gy_sq[19:0];
            d_thr2_reg  <= 16'(threshold_reg) * 16'(threshold_reg);
            d_ax_ge_reg <= c_ax[9:0] >= {2'd0, threshold_reg};

            out_flag_reg <= d_flag;
            out_row_reg  <= d_meta_reg.row;
            out_col_reg  <= d_meta_reg.col;
            out_gx_reg   <= d_gx_reg;
            out_gy_reg   <= d_gy_reg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.edge_flag  = out_flag_reg;
    assign results.center_row = out_row_reg;
    assign results.center_col = out_col_reg;
    assign results.grad_x     = out_gx_reg;
    assign results.grad_y     = out_gy_reg;

    `SOBEL_ASSERT_NEXT(a_border_no_flag, en && d_valid_reg && d_meta_reg.border, !out_flag_reg, "border center produced an edge flag")
    `SOBEL_ASSERT_NEXT(a_fwd_on_hit, acc && a_valid_reg && (a_slot_reg == cur_col), a_fwd_reg, "same-slot read not forwarded")
    `SOBEL_ASSERT_NOW(a_col_in_range, 1'b1, 32'(col_reg) < MAX_WIDTH, "column counter past line store depth")
    `SOBEL_ASSERT_NEXT(a_stall_holds, !en, $stable(a_valid_reg) && $stable(d_valid_reg), "pipeline moved while stalled")

endmodule
